>>> hdl/bpc_pkg.sv
// Shared types and constants for the button press classifier with LED pulse.
// No dependencies; compile this file first.
`default_nettype none

package bpc_pkg;

	localparam int unsigned TS_W       = 32;
	localparam int unsigned DEBOUNCE_W = 16;
	localparam int unsigned LONG_W     = 20;
	localparam int unsigned PULSE_W    = 16;
	localparam int unsigned CFG_DATA_W = 20;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd40;
	localparam logic [LONG_W-1:0]     LONG_RST     = 20'd3000;
	localparam logic [PULSE_W-1:0]    PULSE_RST    = 16'd150;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE    = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_LONG    = 2'd2
	} phase_t;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] short_min;
		logic [LONG_W-1:0]     long_min;
		logic [PULSE_W-1:0]    pulse_len;
	} cfg_t;

	typedef struct packed {
		logic short_event;
		logic long_event;
	} press_ev_t;

endpackage

`default_nettype wire

>>> hdl/bpc_if.sv
// Valid/ready channel interfaces for poll ticks and classifier results.
// No dependencies.
`default_nettype none

interface bpc_tick_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_ms;
	logic        button_down;
	logic        rx_seen;

	modport source (output valid, output now_ms, output button_down, output rx_seen,
		input ready);
	modport sink (input valid, input now_ms, input button_down, input rx_seen,
		output ready);
endinterface

interface bpc_result_if;
	logic valid;
	logic ready;
	logic short_event;
	logic long_event;
	logic led_on;

	modport source (output valid, output short_event, output long_event, output led_on,
		input ready);
	modport sink (input valid, input short_event, input long_event, input led_on,
		output ready);
endinterface

`default_nettype wire

>>> hdl/bpc_cfg_regs.sv
// Configuration registers: debounce, long-press and LED pulse times.
// Depends on bpc_pkg.
`default_nettype none

module bpc_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output bpc_pkg::cfg_t                       cfg
);
	import bpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_min <= DEBOUNCE_RST;
			cfg_q.long_min  <= LONG_RST;
			cfg_q.pulse_len <= PULSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: cfg_q.short_min <= cfg_wdata[DEBOUNCE_W-1:0];
				CFG_LONG:     cfg_q.long_min  <= cfg_wdata[LONG_W-1:0];
				CFG_PULSE:    cfg_q.pulse_len <= cfg_wdata[PULSE_W-1:0];
				default:      ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hdl/bpc_press_fsm.sv
// Press phase machine: classifies holds into short and long presses.
// Depends on bpc_pkg.
`default_nettype none

module bpc_press_fsm (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [bpc_pkg::TS_W-1:0]   now_ms,
	input  wire logic                       button_down,
	input  bpc_pkg::cfg_t                   cfg,
	output bpc_pkg::press_ev_t              ev,
	output bpc_pkg::phase_t                 phase
);
	import bpc_pkg::*;

	phase_t            phase_q;
	phase_t            phase_d;
	logic [TS_W-1:0]   start_q;
	logic [TS_W-1:0]   held;
	logic              debounced;
	logic              long_hit;

	// wrapping hold time
	assign held      = now_ms - start_q;
	assign debounced = held >= {{(TS_W-DEBOUNCE_W){1'b0}}, cfg.short_min};
	assign long_hit  = held >= {{(TS_W-LONG_W){1'b0}}, cfg.long_min};

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_PRESSED: begin
				if (!button_down)
					phase_d = PH_IDLE;
				else if (long_hit)
					phase_d = PH_LONG;
			end
			PH_LONG: begin
				if (!button_down)
					phase_d = PH_IDLE;
			end
			default: begin
				phase_d = button_down ? PH_PRESSED : PH_IDLE;
			end
		endcase
	end

	always_comb begin
		ev = '0;
		case (phase_q)
			PH_PRESSED: begin
				ev.short_event = !button_down && debounced;
				ev.long_event  = button_down && long_hit;
			end
			default: ev = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q != PH_PRESSED && phase_q != PH_LONG && button_down)
				start_q <= now_ms;
		end
	end

	assign phase = phase_q;

endmodule

`default_nettype wire

>>> hdl/bpc_led_timer.sv
// Receive-activity LED timer with a wrapping deadline.
// Depends on bpc_pkg.
`default_nettype none

module bpc_led_timer (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       step,
	input  wire logic [bpc_pkg::TS_W-1:0]   now_ms,
	input  wire logic                       rx_seen,
	input  wire logic [bpc_pkg::PULSE_W-1:0] pulse_len,
	output logic                            led_next
);
	import bpc_pkg::*;

	logic [TS_W-1:0] deadline_q;
	logic            level_q;
	logic [TS_W-1:0] since;
	logic            expired;

	// deadline reached when the wrapping difference is non-negative
	assign since   = now_ms - deadline_q;
	assign expired = level_q && !since[TS_W-1];

	assign led_next = rx_seen || (level_q && !expired);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q <= '0;
			level_q    <= 1'b0;
		end else if (step) begin
			if (rx_seen) begin
				deadline_q <= now_ms + {{(TS_W-PULSE_W){1'b0}}, pulse_len};
				level_q    <= 1'b1;
			end else if (expired) begin
				deadline_q <= '0;
				level_q    <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/button_press_classifier_led_pulse_core.sv
// Top level: input register, press classifier, LED timer and result register.
// Depends on bpc_pkg, bpc_if, bpc_cfg_regs, bpc_press_fsm, bpc_led_timer.
//
//   port     dir  handshake      payload
//   in_ch    in   valid/ready    now_ms[31:0], button_down, rx_seen
//   out_ch   out  valid/ready    short_event, long_event, led_on
//   cfg_*    in   cfg_we only    cfg_index[1:0], cfg_wdata[19:0]
//
// One request per cycle sustained while out_ch is ready; path: input register,
// then result register, with the single-pass compare/add logic between them.
// Reset: phase idle, LED off, registers at 40 / 3000 / 150 ms.
// A stalled result holds the result register; the input register still takes a
// new request while empty, and in_ch.ready drops only when both registers are full.
`default_nettype none

module button_press_classifier_led_pulse_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bpc_tick_if.sink                            in_ch,
	bpc_result_if.source                        out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bpc_pkg::*;

	cfg_t            cfg;
	logic            valid_s1;
	logic [TS_W-1:0] now_s1;
	logic            button_s1;
	logic            rx_s1;
	logic            adv_s1;
	press_ev_t       ev;
	phase_t          phase;
	logic            led_next;
	logic            out_valid_q;
	press_ev_t       ev_q;
	logic            led_q;

	bpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv_s1      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			now_s1    <= in_ch.now_ms;
			button_s1 <= in_ch.button_down;
			rx_s1     <= in_ch.rx_seen;
		end
	end

	bpc_press_fsm u_press (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.now_ms      (now_s1),
		.button_down (button_s1),
		.cfg         (cfg),
		.ev          (ev),
		.phase       (phase)
	);

	bpc_led_timer u_led (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.now_ms    (now_s1),
		.rx_seen   (rx_s1),
		.pulse_len (cfg.pulse_len),
		.led_next  (led_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			ev_q  <= ev;
			led_q <= led_next;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.short_event = ev_q.short_event;
	assign out_ch.long_event  = ev_q.long_event;
	assign out_ch.led_on      = led_q;

	a_ev_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.short_event && out_ch.long_event))
		else $error("short and long press reported on the same tick");

	a_long_enters_long: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && ev.long_event) |=> (phase == PH_LONG))
		else $error("long press reported without entering long phase");

	a_short_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && ev.short_event) |=> (phase == PH_IDLE))
		else $error("short press reported without returning to idle");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> !in_ch.ready)
		else $error("input taken while the input register is held");

endmodule

`default_nettype wire
